@@ rtl/core/fq_pkg.sv @@
package fq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int WORD_BITS = 16;

  // branch vector width: word sums plus ONE, with headroom
  localparam int VW = ((WORD_BITS > FRAC_BITS + 1) ? WORD_BITS : FRAC_BITS + 1) + 3;
  localparam int PB = $clog2(VW);
  // cross-term and final saturation width
  localparam int CW = ((2 * WORD_BITS > FRAC_BITS) ? 2 * WORD_BITS : FRAC_BITS) + 3;
  localparam int NORM_BITS = 31;
  localparam int NORM_LO = 29;
  localparam int SUM_BITS = 64;
  localparam int ROOT_BITS = 32;
  localparam int QB = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 34;
  localparam int DEPTH = 7 + ROOT_BITS + 1 + QB + 1;

  localparam longint WMAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam logic signed [CW-1:0] CW_MAX = CW'(WMAX);
  localparam logic signed [CW-1:0] CW_MIN = -CW_MAX - CW'(1);
  localparam logic signed [CW-1:0] CW_HALF = CW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [VW-1:0] ONE_V = VW'(longint'(1) <<< FRAC_BITS);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] normal_x;
    logic signed [WORD_BITS-1:0] normal_y;
    logic signed [WORD_BITS-1:0] normal_z;
    logic signed [WORD_BITS-1:0] tangent_x;
    logic signed [WORD_BITS-1:0] tangent_y;
    logic signed [WORD_BITS-1:0] tangent_z;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] q_w;
    logic signed [WORD_BITS-1:0] q_x;
    logic signed [WORD_BITS-1:0] q_y;
    logic signed [WORD_BITS-1:0] q_z;
    logic                        invalid;
    logic                        degenerate;
  } out_t;

  typedef struct packed {
    logic [3:0][NORM_BITS-1:0] nm;
    logic [3:0]                neg;
    logic                      inv;
    logic                      dgn;
  } side_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] y;
    y = x;
    if (x > CW_MAX) y = CW_MAX;
    else if (x < CW_MIN) y = CW_MIN;
    return y[WORD_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/frame_to_quaternion_top.sv @@
// channel | dir | type           | handshake
// in      | in  | fq_pkg::in_t   | in_valid / in_ready, beat on both high
// out     | out | fq_pkg::out_t  | out_valid / out_ready, beat on both high
//
// One beat per cycle while the output is not stalled; the stages, in order:
// products, cross terms, branch, leading one, shift, squares, sum, one root bit
// per stage (32), divide set-up, one quotient bit per stage (FRAC_BITS+2), output.
// The whole pipe advances together; it holds while the output beat waits.
// rst is synchronous and clears only the valid bits.
module frame_to_quaternion_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fq_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fq_pkg::out_t  out_data
);

  localparam int W  = fq_pkg::WORD_BITS;
  localparam int VW = fq_pkg::VW;
  localparam int NB = fq_pkg::NORM_BITS;
  localparam int RB = fq_pkg::ROOT_BITS;
  localparam int QB = fq_pkg::QB;
  localparam int DW = fq_pkg::DW;
  localparam int D  = fq_pkg::DEPTH;

  logic         en;
  logic [D-1:0] vld;

  assign en        = out_ready | ~vld[D-1];
  assign in_ready  = en;
  assign out_valid = vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  // S1: products
  fq_pkg::in_t               s1_in;
  logic signed [2*W-1:0]     p [6];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_in <= in_data;
      p[0]  <= in_data.normal_y * in_data.tangent_z;
      p[1]  <= in_data.normal_z * in_data.tangent_y;
      p[2]  <= in_data.normal_z * in_data.tangent_x;
      p[3]  <= in_data.normal_x * in_data.tangent_z;
      p[4]  <= in_data.normal_x * in_data.tangent_y;
      p[5]  <= in_data.normal_y * in_data.tangent_x;
    end
  end

  // S2: bitangent, rounded half up and saturated
  fq_pkg::in_t               s2_in;
  logic signed [W-1:0]       b [3];
  logic signed [fq_pkg::CW-1:0] cd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd[i] = (fq_pkg::CW'(p[2*i]) - fq_pkg::CW'(p[2*i+1]) + fq_pkg::CW_HALF)
              >>> fq_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_in <= s1_in;
      for (int i = 0; i < 3; i++) b[i] <= fq_pkg::sat_word(cd[i]);
    end
  end

  // S3: branch select
  logic signed [VW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, arg;
  logic signed [VW-1:0] v [4];
  logic [3:0][VW-1:0]   s3_mag;
  logic [3:0]           s3_neg;
  logic                 s3_inv, s3_dgn;

  always_comb begin
    m00 = VW'(s2_in.tangent_x);  m01 = VW'(b[0]);  m02 = VW'(s2_in.normal_x);
    m10 = VW'(s2_in.tangent_y);  m11 = VW'(b[1]);  m12 = VW'(s2_in.normal_y);
    m20 = VW'(s2_in.tangent_z);  m21 = VW'(b[2]);  m22 = VW'(s2_in.normal_z);
    tr  = m00 + m11 + m22;
    if (tr > 0) begin
      arg  = tr + fq_pkg::ONE_V;
      v[0] = arg;        v[1] = m21 - m12;  v[2] = m02 - m20;  v[3] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      arg  = fq_pkg::ONE_V + m00 - m11 - m22;
      v[0] = m21 - m12;  v[1] = arg;        v[2] = m01 + m10;  v[3] = m02 + m20;
    end else if (m11 > m22) begin
      arg  = fq_pkg::ONE_V + m11 - m00 - m22;
      v[0] = m02 - m20;  v[1] = m01 + m10;  v[2] = arg;        v[3] = m12 + m21;
    end else begin
      arg  = fq_pkg::ONE_V + m22 - m00 - m11;
      v[0] = m10 - m01;  v[1] = m02 + m20;  v[2] = m12 + m21;  v[3] = arg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s3_mag[i] <= v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
        s3_neg[i] <= v[i][VW-1];
      end
      s3_inv <= (arg <= 0);
      s3_dgn <= (arg > 0) && (v[0] == 0) && (v[1] == 0) && (v[2] == 0) && (v[3] == 0);
    end
  end

  // S4: leading one of the largest magnitude, found from the OR of all four
  logic [VW-1:0]          orv;
  logic [fq_pkg::PB-1:0]  pos;
  logic [3:0][VW-1:0]     s4_mag;
  logic [3:0]             s4_neg;
  logic                   s4_inv, s4_dgn, s4_right;
  logic [fq_pkg::PB-1:0]  s4_amt;

  always_comb begin
    orv = s3_mag[0] | s3_mag[1] | s3_mag[2] | s3_mag[3];
    pos = '0;
    for (int i = 0; i < VW; i++) begin
      if (orv[i]) pos = fq_pkg::PB'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_inv   <= s3_inv;
      s4_dgn   <= s3_dgn;
      s4_right <= pos > fq_pkg::PB'(NB - 1);
      if (pos > fq_pkg::PB'(NB - 1))             s4_amt <= pos - fq_pkg::PB'(NB - 1);
      else if (pos < fq_pkg::PB'(fq_pkg::NORM_LO)) s4_amt <= fq_pkg::PB'(fq_pkg::NORM_LO) - pos;
      else                                        s4_amt <= '0;
    end
  end

  // S5: normalise into [2^29, 2^31)
  fq_pkg::side_t s5, s6;
  logic [VW+NB-1:0] shv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shv[i] = s4_right ? ((VW+NB)'(s4_mag[i]) >> s4_amt)
                        : ((VW+NB)'(s4_mag[i]) << s4_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) s5.nm[i] <= shv[i][NB-1:0];
      s5.neg <= s4_neg;
      s5.inv <= s4_inv;
      s5.dgn <= s4_dgn;
    end
  end

  // S6: squares, S7: sum
  logic [2*NB-1:0] sq [4];
  logic [fq_pkg::SUM_BITS-1:0] sv [RB+1];
  logic [fq_pkg::SUM_BITS-1:0] sr [RB+1];
  fq_pkg::side_t               sside [RB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s6 <= s5;
      for (int i = 0; i < 4; i++) sq[i] <= s5.nm[i] * s5.nm[i];
      sside[0] <= s6;
      sr[0]    <= '0;
      sv[0] <= fq_pkg::SUM_BITS'(sq[0]) + fq_pkg::SUM_BITS'(sq[1])
             + fq_pkg::SUM_BITS'(sq[2]) + fq_pkg::SUM_BITS'(sq[3]);
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam logic [fq_pkg::SUM_BITS-1:0] BIT = fq_pkg::SUM_BITS'(1) << (62 - 2*k);
    logic [fq_pkg::SUM_BITS-1:0] trial;
    assign trial = sr[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sside[k+1] <= sside[k];
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  // divide set-up: rounded numerator
  logic [RB-1:0]          len;
  logic [3:0][DW-1:0]     rem  [QB+1];
  logic [3:0][QB-1:0]     quo  [QB+1];
  logic [RB-1:0]          dlen [QB+1];
  logic [3:0]             dneg [QB+1];
  logic                   dinv [QB+1];
  logic                   ddgn [QB+1];

  assign len = (sr[RB][RB-1:0] == '0) ? RB'(1) : sr[RB][RB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        rem[0][i] <= (DW'(sside[RB].nm[i]) << fq_pkg::FRAC_BITS) + DW'(len >> 1);
      end
      quo[0]  <= '0;
      dlen[0] <= len;
      dneg[0] <= sside[RB].neg;
      dinv[0] <= sside[RB].inv;
      ddgn[0] <= sside[RB].dgn;
    end
  end

  // restoring division, one quotient bit per stage, four lanes
  for (genvar d = 0; d < QB; d++) begin : g_div
    logic [DW-1:0] dtrial;
    assign dtrial = DW'(dlen[d]) << (QB - 1 - d);
    always_ff @(posedge clk) begin
      if (en) begin
        dlen[d+1] <= dlen[d];
        dneg[d+1] <= dneg[d];
        dinv[d+1] <= dinv[d];
        ddgn[d+1] <= ddgn[d];
        for (int i = 0; i < 4; i++) begin
          if (rem[d][i] >= dtrial) begin
            rem[d+1][i] <= rem[d][i] - dtrial;
            quo[d+1][i] <= quo[d][i] | (QB'(1) << (QB - 1 - d));
          end else begin
            rem[d+1][i] <= rem[d][i];
            quo[d+1][i] <= quo[d][i];
          end
        end
      end
    end
  end

  // output: sign, saturate, flag overrides
  logic signed [fq_pkg::CW-1:0] qs [4];
  logic signed [W-1:0]          qw [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = dneg[QB][i] ? -fq_pkg::CW'(quo[QB][i]) : fq_pkg::CW'(quo[QB][i]);
      qw[i] = (dinv[QB] || ddgn[QB]) ? '0 : fq_pkg::sat_word(qs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.q_w        <= qw[0];
      out_data.q_x        <= qw[1];
      out_data.q_y        <= qw[2];
      out_data.q_z        <= qw[3];
      out_data.invalid    <= dinv[QB];
      out_data.degenerate <= ddgn[QB] & ~dinv[QB];
    end
  end

endmodule

@@ rtl/core/fq_checker.sv @@
module fq_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input fq_pkg::out_t out_data
);

  // a held output beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // pipe stops taking beats while the output is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.invalid && out_data.degenerate))
    else $error("both flags set");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.invalid || out_data.degenerate) |->
      out_data.q_w == '0 && out_data.q_x == '0 && out_data.q_y == '0 && out_data.q_z == '0)
    else $error("flagged beat with non-zero quaternion");

endmodule

bind frame_to_quaternion_top fq_checker u_fq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ bench/frame_to_quaternion_top_test.sv @@
`timescale 1ns / 100ps

module frame_to_quaternion_top_test;

  localparam int TOTAL_RANDOM = 1550;
  localparam int LIMIT_CYCLES = 400000;
  localparam longint ONE = longint'(1) <<< fq_pkg::FRAC_BITS;
  localparam longint WHI = (longint'(1) <<< (fq_pkg::WORD_BITS - 1)) - 1;
  localparam longint WLO = -WHI - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fq_pkg::out_t out_data;

  fq_pkg::out_t quat_queue[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;

  frame_to_quaternion_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic longint floor_shr(longint x, int k);
    return x >>> k;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > WHI) return WHI;
    if (v < WLO) return WLO;
    return v;
  endfunction

  function automatic longint cross_round(longint a, longint b, longint c, longint d);
    longint p1, p2, h1, h2, l1, l2;
    p1 = a * b;
    p2 = c * d;
    h1 = floor_shr(p1, fq_pkg::FRAC_BITS);
    h2 = floor_shr(p2, fq_pkg::FRAC_BITS);
    l1 = p1 - h1 * ONE;
    l2 = p2 - h2 * ONE;
    return clamp_word((h1 - h2) + floor_shr(l1 - l2 + (ONE >>> 1), fq_pkg::FRAC_BITS));
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic fq_pkg::out_t frame_quat(fq_pkg::in_t f);
    longint n0, n1, n2, t0, t1, t2, b0, b1, b2, tr, arg, q;
    longint v[4];
    longint unsigned mag[4], mx, sum, len, qm;
    fq_pkg::out_t r;
    n0 = f.normal_x; n1 = f.normal_y; n2 = f.normal_z;
    t0 = f.tangent_x; t1 = f.tangent_y; t2 = f.tangent_z;
    b0 = cross_round(n1, t2, n2, t1);
    b1 = cross_round(n2, t0, n0, t2);
    b2 = cross_round(n0, t1, n1, t0);
    // columns t, b, n: m00=t0 m01=b0 m02=n0 / m10=t1 m11=b1 m12=n1 / m20=t2 m21=b2 m22=n2
    r = '0;
    tr = t0 + b1 + n2;
    if (tr > 0) begin
      arg = tr + ONE;
      v[0] = arg; v[1] = b2 - n1; v[2] = n0 - t2; v[3] = t1 - b0;
    end else if (t0 > b1 && t0 > n2) begin
      arg = ONE + t0 - b1 - n2;
      v[0] = b2 - n1; v[1] = arg; v[2] = b0 + t1; v[3] = n0 + t2;
    end else if (b1 > n2) begin
      arg = ONE + b1 - t0 - n2;
      v[0] = n0 - t2; v[1] = b0 + t1; v[2] = arg; v[3] = n1 + b2;
    end else begin
      arg = ONE + n2 - t0 - b1;
      v[0] = t1 - b0; v[1] = n0 + t2; v[2] = n1 + b2; v[3] = arg;
    end
    if (arg <= 0) begin
      r.invalid = 1'b1;
      return r;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    len = int_root(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 4; i++) begin
      qm = ((mag[i] << fq_pkg::FRAC_BITS) + (len >> 1)) / len;
      q = longint'(qm);
      if (v[i] < 0) q = -q;
      q = clamp_word(q);
      case (i)
        0: r.q_w = q[fq_pkg::WORD_BITS-1:0];
        1: r.q_x = q[fq_pkg::WORD_BITS-1:0];
        2: r.q_y = q[fq_pkg::WORD_BITS-1:0];
        default: r.q_z = q[fq_pkg::WORD_BITS-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [fq_pkg::WORD_BITS-1:0] w(longint x);
    return x[fq_pkg::WORD_BITS-1:0];
  endfunction

  function automatic logic [fq_pkg::WORD_BITS-1:0] rand_comp(int kind);
    longint x;
    case (kind)
      0: x = $urandom;
      1: x = longint'($urandom_range(0, 2 * ONE)) - ONE;
      2: x = $urandom_range(0, 1) ? WHI : WLO;
      default: x = longint'($urandom_range(0, 64)) - 32;
    endcase
    return w(x);
  endfunction

  // random frame: mostly near-unit rotations, else arbitrary bits, +-ONE or extremes
  function automatic fq_pkg::in_t rand_frame();
    fq_pkg::in_t f;
    int k, pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      k = $urandom_range(0, 2);
      f.normal_x = rand_comp(3); f.normal_y = rand_comp(3); f.normal_z = rand_comp(3);
      f.tangent_x = rand_comp(3); f.tangent_y = rand_comp(3); f.tangent_z = rand_comp(3);
      case ($urandom_range(0, 5))
        0: begin f.normal_z = w(ONE); f.tangent_x = w(ONE); end
        1: begin f.normal_z = w(-ONE); f.tangent_x = w(ONE); end
        2: begin f.normal_x = w(ONE); f.tangent_y = w(ONE); end
        3: begin f.normal_y = w(ONE); f.tangent_z = w(-ONE); end
        4: begin f.normal_x = w(-ONE); f.tangent_z = w(ONE); end
        default: begin f.normal_y = w(-ONE); f.tangent_x = w(-ONE); end
      endcase
      if (k == 0) f.normal_x = rand_comp(1);
    end else begin
      k = (pick == 9) ? 2 : (pick == 8 ? 0 : 1);
      f.normal_x = rand_comp(k); f.normal_y = rand_comp(k); f.normal_z = rand_comp(k);
      f.tangent_x = rand_comp(k); f.tangent_y = rand_comp(k); f.tangent_z = rand_comp(k);
    end
    return f;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_beat(fq_pkg::in_t f);
    in_data <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    quat_queue = {quat_queue, frame_quat(f)};
    @(negedge clk);
  endtask

  task automatic idle_tx(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // directed rows; the expectation is typed in where it is obvious
  typedef struct {
    fq_pkg::in_t frame;
    bit typed;
    fq_pkg::out_t quat;
  } row_t;

  row_t rows[$];

  task automatic add_row(longint nx, ny, nz, tx, ty, tz, bit typed = 0,
                         fq_pkg::out_t q = '0);
    row_t r;
    r.frame = '{w(nx), w(ny), w(nz), w(tx), w(ty), w(tz)};
    r.typed = typed;
    r.quat = q;
    rows = {rows, r};
  endtask

  initial begin
    fq_pkg::out_t q_ident, q_zero;
    q_ident = '{w(ONE), 16'd0, 16'd0, 16'd0, 1'b0, 1'b0};
    q_zero = '{16'd0, 16'd0, 16'd0, w(ONE), 1'b0, 1'b0};
    // identity frame
    add_row(0, 0, ONE, ONE, 0, 0, 1, q_ident);
    // all zero: trace 0, last branch, arg = ONE -> z only
    add_row(0, 0, 0, 0, 0, 0, 1, q_zero);
    // large negative diagonal entries, bitangent saturates
    add_row(0, 0, WLO, WLO, 0, 0);
    add_row(0, 0, -ONE, -ONE, 0, 0);
    add_row(ONE, 0, 0, 0, ONE, 0);
    add_row(0, ONE, 0, 0, 0, ONE);
    add_row(0, 0, -ONE, ONE, 0, 0);
    add_row(0, -ONE, 0, -ONE, 0, 0);
    add_row(WHI, WHI, WHI, WHI, WHI, WHI);
    add_row(WLO, WLO, WLO, WLO, WLO, WLO);
    add_row(WHI, WLO, WHI, WLO, WHI, WLO);
    add_row(WLO, WHI, WLO, WHI, WLO, WHI);
    add_row(-1, -1, -1, -1, -1, -1);
    add_row(1, 1, 1, 1, 1, 1);
    add_row(0, WHI, 0, WLO, 0, 0);
    add_row(WLO, 0, 0, 0, WLO, 0);
    add_row(11585, 0, 11585, 11585, 0, -11585);
    add_row(0, 0, ONE, 0, ONE, 0);
    add_row(0, 0, 0, WHI, 0, 0);
    add_row(-ONE, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_beat(rows[i].frame);
      if (rows[i].typed && quat_queue[$] != rows[i].quat) begin
        $error("row %0d: predictor disagrees with typed value", i);
        errors++;
      end
      quat_queue[$] = rows[i].typed ? rows[i].quat : quat_queue[$];
    end
    idle_tx(1);
    for (int n = 0; n < TOTAL_RANDOM; n++) begin
      if (n == 300) hold_rx = 1'b1;
      if (n == 700) begin
        in_valid <= 1'b0;
        while (quat_queue.size() != 0) @(negedge clk);
      end
      if (n > 40 && n < 1200 && $urandom_range(0, 3) == 0) idle_tx(gap_len());
      else if (n >= 1200 && n < 1300) idle_tx(0);
      else if ($urandom_range(0, 3) == 0) idle_tx(gap_len());
      send_beat(rand_frame());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
      n = $urandom_range(0, 99);
      if (n < 60 || (cycles > 60000 && cycles < 62000)) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    fq_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (quat_queue.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = quat_queue.pop_front();
        if (out_data.q_w !== e.q_w) begin
          $error("q_w: expected %0d, got %0d", e.q_w, out_data.q_w); errors++;
        end
        if (out_data.q_x !== e.q_x) begin
          $error("q_x: expected %0d, got %0d", e.q_x, out_data.q_x); errors++;
        end
        if (out_data.q_y !== e.q_y) begin
          $error("q_y: expected %0d, got %0d", e.q_y, out_data.q_y); errors++;
        end
        if (out_data.q_z !== e.q_z) begin
          $error("q_z: expected %0d, got %0d", e.q_z, out_data.q_z); errors++;
        end
        if (out_data.invalid !== e.invalid) begin
          $error("invalid: expected %0b, got %0b", e.invalid, out_data.invalid); errors++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate: expected %0b, got %0b", e.degenerate, out_data.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    while (!(stim_done && quat_queue.size() == 0) && cycles < LIMIT_CYCLES)
      @(posedge clk);
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
    end else begin
      repeat (2 * fq_pkg::DEPTH + 10) @(posedge clk);
      if (errors == 0 && quat_queue.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

endmodule

@@ frame_to_quaternion_top.f @@
rtl/core/fq_pkg.sv
rtl/core/frame_to_quaternion_top.sv
rtl/core/fq_checker.sv
bench/frame_to_quaternion_top_test.sv
